// ===== design/pvi_pkg.sv =====
package pvi_pkg;

  // Pipeline depth of one axis lane (register stages)
  localparam int unsigned LANE_STAGES = 6;
  localparam int unsigned NUM_AXES    = 3;

  // Wall tolerance of 0.001 in Q16.16 (nearest)
  localparam logic signed [33:0] WALL_TOL_Q16 = 34'sd66;

  // Register reset values
  localparam logic [15:0]        TIME_STEP_RST = 16'd655;
  localparam logic signed [17:0] DAMPING_RST   = -18'sd32768;
  localparam logic signed [31:0] BOX_MIN_RST   = -32'sd65536;
  localparam logic signed [31:0] BOX_MAX_RST   = 32'sd65536;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_TIME_STEP = 4'd0,
    REG_DAMPING   = 4'd1,
    REG_BOX_MIN_X = 4'd2,
    REG_BOX_MIN_Y = 4'd3,
    REG_BOX_MIN_Z = 4'd4,
    REG_BOX_MAX_X = 4'd5,
    REG_BOX_MAX_Y = 4'd6,
    REG_BOX_MAX_Z = 4'd7
  } reg_idx_e;

  // Input request: one particle
  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] prev_accel_x;
    logic signed [31:0] prev_accel_y;
    logic signed [31:0] prev_accel_z;
    logic signed [31:0] vel_in_x;
    logic signed [31:0] vel_in_y;
    logic signed [31:0] vel_in_z;
    logic signed [31:0] pos_in_x;
    logic signed [31:0] pos_in_y;
    logic signed [31:0] pos_in_z;
  } in_req_t;

  // Output response: updated particle
  typedef struct packed {
    logic signed [31:0] pos_out_x;
    logic signed [31:0] pos_out_y;
    logic signed [31:0] pos_out_z;
    logic signed [31:0] vel_out_x;
    logic signed [31:0] vel_out_y;
    logic signed [31:0] vel_out_z;
    logic signed [31:0] accel_out_x;
    logic signed [31:0] accel_out_y;
    logic signed [31:0] accel_out_z;
  } out_rsp_t;

  // One axis worth of particle state into a lane
  typedef struct packed {
    logic signed [31:0] force_v;
    logic signed [31:0] prev_accel;
    logic signed [31:0] vel;
    logic signed [31:0] pos;
  } lane_in_t;

  // One axis worth of results out of a lane
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] accel;
  } lane_out_t;

  // Per-lane view of the configuration registers
  typedef struct packed {
    logic [15:0]        dt;
    logic signed [17:0] damping;
    logic signed [31:0] box_min;
    logic signed [31:0] box_max;
  } lane_cfg_t;

  // Clip to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/pvi_lane.sv =====
module pvi_lane
  import pvi_pkg::*;
#(
  parameter int unsigned INV_MASS_Q16 = 65536
) (
  input  logic                   clk_i,
  input  logic [LANE_STAGES-1:0] en_i,
  input  lane_cfg_t              cfg_i,
  input  lane_in_t               in_i,
  output lane_out_t              out_o
);

  localparam int unsigned InvW = $clog2(INV_MASS_Q16 + 1) + 1;
  localparam logic signed [InvW-1:0] InvMass = InvW'(INV_MASS_Q16);

  logic signed [16:0] dt_s;
  assign dt_s = $signed({1'b0, cfg_i.dt});

  // Stage 1: new acceleration = force * inverse mass
  logic signed [31+InvW:0] force_prod;
  logic signed [31:0] a1_q, aold1_q, vin1_q, pin1_q;

  assign force_prod = in_i.force_v * InvMass;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a1_q    <= sat32(64'(force_prod >>> 16));
      aold1_q <= in_i.prev_accel;
      vin1_q  <= in_i.vel;
      pin1_q  <= in_i.pos;
    end
  end

  // Stage 2: mean acceleration times dt, and a * dt
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_mean;
  logic signed [48:0] pm2_q, pad2_q;
  logic signed [31:0] a2_q, vin2_q, pin2_q;

  assign acc_sum  = {a1_q[31], a1_q} + {aold1_q[31], aold1_q};
  assign acc_mean = acc_sum[32:1];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pm2_q  <= dt_s * acc_mean;
      pad2_q <= a1_q * dt_s;
      a2_q   <= a1_q;
      vin2_q <= vin1_q;
      pin2_q <= pin1_q;
    end
  end

  // Stage 3: new velocity, and a * dt * dt / 2^33
  logic signed [65:0] pdd;
  logic signed [31:0] v3_q, acc3_q, a3_q, pin3_q;

  assign pdd = pad2_q * dt_s;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      v3_q   <= sat32(64'(vin2_q) + 64'(pm2_q >>> 16));
      acc3_q <= pdd[64:33];
      a3_q   <= a2_q;
      pin3_q <= pin2_q;
    end
  end

  // Stage 4: dt * velocity
  logic signed [48:0] pv4_q;
  logic signed [31:0] v4_q, acc4_q, a4_q, pin4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      pv4_q  <= dt_s * v3_q;
      v4_q   <= v3_q;
      acc4_q <= acc3_q;
      a4_q   <= a3_q;
      pin4_q <= pin3_q;
    end
  end

  // Stage 5: new position, and velocity times damping for a wall hit
  logic signed [31:0] p5_q, v5_q, a5_q;
  logic signed [49:0] vd5_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      p5_q  <= sat32(64'(pin4_q) + 64'(pv4_q >>> 16) + 64'(acc4_q));
      vd5_q <= v4_q * cfg_i.damping;
      v5_q  <= v4_q;
      a5_q  <= a4_q;
    end
  end

  // Stage 6: wall test; lower bound is checked first and wins
  logic signed [33:0] lo_lim, hi_lim, p_ext;
  logic               lo_hit, hi_hit;
  logic signed [31:0] v_damp;
  logic signed [31:0] p6_q, v6_q, a6_q;

  assign lo_lim = 34'(cfg_i.box_min) - WALL_TOL_Q16;
  assign hi_lim = 34'(cfg_i.box_max) + WALL_TOL_Q16;
  assign p_ext  = 34'(p5_q);
  assign lo_hit = p_ext < lo_lim;
  assign hi_hit = !lo_hit && (p_ext > hi_lim);
  assign v_damp = sat32(64'(vd5_q >>> 16));

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      priority if (lo_hit) begin
        p6_q <= cfg_i.box_min;
        v6_q <= v_damp;
      end else if (hi_hit) begin
        p6_q <= cfg_i.box_max;
        v6_q <= v_damp;
      end else begin
        p6_q <= p5_q;
        v6_q <= v5_q;
      end
      a6_q <= a5_q;
    end
  end

  assign out_o.pos   = p6_q;
  assign out_o.vel   = v6_q;
  assign out_o.accel = a6_q;

endmodule

// ===== design/pvi_merge.sv =====
module pvi_merge
  import pvi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  lane_out_t lane_x_i,
  input  lane_out_t lane_y_i,
  input  lane_out_t lane_z_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_rsp_t  out_rsp_o
);

  logic     valid_q;
  out_rsp_t rsp_q, rsp_d;

  // Gather the three lanes into one response
  always_comb begin
    rsp_d.pos_out_x   = lane_x_i.pos;
    rsp_d.pos_out_y   = lane_y_i.pos;
    rsp_d.pos_out_z   = lane_z_i.pos;
    rsp_d.vel_out_x   = lane_x_i.vel;
    rsp_d.vel_out_y   = lane_y_i.vel;
    rsp_d.vel_out_z   = lane_z_i.vel;
    rsp_d.accel_out_x = lane_x_i.accel;
    rsp_d.accel_out_y = lane_y_i.accel;
    rsp_d.accel_out_z = lane_z_i.accel;
  end

  // Output register takes a new request once the held one drains
  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== design/particle_verlet_integrate_walls.sv =====
// Velocity Verlet particle update with box walls. Takes one particle request per clock
// on in_req_i while in_ready_o is high and returns one response per request on
// out_rsp_o, in order, after six register stages in each of the three per-axis lanes
// plus the output register. Stages advance on their own, so bubbles collapse and new
// requests enter, while a stage is free, as a finished response waits on out_ready_i.
// Registers on the cfg port: 0 time step, 1 wall damping, 2..4 box minimum x/y/z,
// 5..7 box maximum x/y/z; other indexes are ignored. Write them only while the block
// holds no request.
module particle_verlet_integrate_walls
  import pvi_pkg::*;
#(
  parameter int unsigned INV_MASS_Q16 = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_rsp_t    out_rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration registers
  logic [15:0]        dt_q;
  logic signed [17:0] damping_q;
  logic signed [31:0] box_min_q [NUM_AXES];
  logic signed [31:0] box_max_q [NUM_AXES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q      <= TIME_STEP_RST;
      damping_q <= DAMPING_RST;
      for (int i = 0; i < NUM_AXES; i++) begin
        box_min_q[i] <= BOX_MIN_RST;
        box_max_q[i] <= BOX_MAX_RST;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TIME_STEP: dt_q         <= cfg_data_i[15:0];
        REG_DAMPING:   damping_q    <= cfg_data_i[17:0];
        REG_BOX_MIN_X: box_min_q[0] <= cfg_data_i;
        REG_BOX_MIN_Y: box_min_q[1] <= cfg_data_i;
        REG_BOX_MIN_Z: box_min_q[2] <= cfg_data_i;
        REG_BOX_MAX_X: box_max_q[0] <= cfg_data_i;
        REG_BOX_MAX_Y: box_max_q[1] <= cfg_data_i;
        REG_BOX_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lane_cfg_t lane_cfg [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      lane_cfg[i].dt      = dt_q;
      lane_cfg[i].damping = damping_q;
      lane_cfg[i].box_min = box_min_q[i];
      lane_cfg[i].box_max = box_max_q[i];
    end
  end

  // Stage valids and enables; a stage moves when it is empty or the next one moves
  logic [LANE_STAGES-1:0] stg_valid_q;
  logic [LANE_STAGES-1:0] stg_en;
  logic                   mrg_ready;

  always_comb begin
    stg_en[LANE_STAGES-1] = !stg_valid_q[LANE_STAGES-1] || mrg_ready;
    for (int k = LANE_STAGES - 2; k >= 0; k--) begin
      stg_en[k] = !stg_valid_q[k] || stg_en[k+1];
    end
  end

  assign in_ready_o = stg_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= '0;
    end else begin
      if (stg_en[0]) begin
        stg_valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < LANE_STAGES; k++) begin
        if (stg_en[k]) begin
          stg_valid_q[k] <= stg_valid_q[k-1];
        end
      end
    end
  end

  // Split the request into per-axis lanes
  lane_in_t  lane_in  [NUM_AXES];
  lane_out_t lane_out [NUM_AXES];

  always_comb begin
    lane_in[0].force_v    = in_req_i.force_x;
    lane_in[0].prev_accel = in_req_i.prev_accel_x;
    lane_in[0].vel        = in_req_i.vel_in_x;
    lane_in[0].pos        = in_req_i.pos_in_x;
    lane_in[1].force_v    = in_req_i.force_y;
    lane_in[1].prev_accel = in_req_i.prev_accel_y;
    lane_in[1].vel        = in_req_i.vel_in_y;
    lane_in[1].pos        = in_req_i.pos_in_y;
    lane_in[2].force_v    = in_req_i.force_z;
    lane_in[2].prev_accel = in_req_i.prev_accel_z;
    lane_in[2].vel        = in_req_i.vel_in_z;
    lane_in[2].pos        = in_req_i.pos_in_z;
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    pvi_lane #(
      .INV_MASS_Q16(INV_MASS_Q16)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (stg_en),
      .cfg_i (lane_cfg[g]),
      .in_i  (lane_in[g]),
      .out_o (lane_out[g])
    );
  end

  // Merge lanes into the output register
  pvi_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_valid_q[LANE_STAGES-1]),
    .ready_o     (mrg_ready),
    .lane_x_i    (lane_out[0]),
    .lane_y_i    (lane_out[1]),
    .lane_z_i    (lane_out[2]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== design/pvi_checker.sv =====
module pvi_checker
  import pvi_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_rsp_t    out_rsp_o,
  input logic        cfg_ready_o
);

  localparam logic [3:0] MaxInFlight = 4'(LANE_STAGES + 1);

  // Requests accepted but not yet delivered
  logic [3:0] inflight_q, inflight_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 4'd1;
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // No response without an outstanding request
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 4'd0)
    else $error("response with no outstanding request");

  // Never more in flight than the pipeline holds
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= MaxInFlight)
    else $error("more requests in flight than pipeline depth");

  // A waiting response holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind particle_verlet_integrate_walls pvi_checker u_pvi_checker (.*);
